// ----- hdl/assert_macros.svh -----
// Assertion macros used by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/tcw_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helpers of the text console character writer.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int LIN_W    = 11;
  localparam int CELL_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int FG_W     = 4;
  localparam int BG_W     = 3;
  localparam int ADDR_W   = $clog2(CELL_COUNT);
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 40;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F00;
  localparam logic [FG_W-1:0]   FG_RESET   = 4'd15;
  localparam logic [BG_W-1:0]   BG_RESET   = 3'd0;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Register index, taken from paddr bit 2
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic REG_BACK_COLOR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDATA,
    ST_FILL,
    ST_COPY,
    ST_ZERO,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CELL_W-1:0]   wr_data;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                scroll;
    logic                clear;
  } put_plan_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

// ----- hdl/tcw_cell_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with registered read data.
module tcw_cell_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/tcw_put_plan.sv -----
`timescale 1ns / 1ps
// Decode of one put character: cell write, new cursor, scroll and clear requests.
module tcw_put_plan
  import tcw_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ROW_W-1:0]  cur_row,
  input  logic [COL_W-1:0]  cur_col,
  input  logic [FG_W-1:0]   text_color,
  input  logic [BG_W-1:0]   back_color,
  output put_plan_t         plan
);

  logic [ROW_W:0] row_e;
  logic [COL_W:0] col_e;

  always_comb begin
    plan         = '0;
    row_e        = {1'b0, cur_row};
    col_e        = {1'b0, cur_col};
    plan.wr_addr = cell_addr(cur_row, cur_col);
    case (char_code)
      CH_BS: begin
        if (cur_col != '0) begin
          col_e        = col_e - 1'b1;
          plan.wr_en   = 1'b1;
          plan.wr_addr = cell_addr(cur_row, cur_col - 1'b1);
          plan.wr_data = BLANK_CELL;
        end
      end
      CH_TAB: begin
        col_e = (COL_W+1)'(({1'b0, cur_col} / TAB_STOP + 1) * TAB_STOP);
      end
      CH_LF: begin
        row_e = row_e + 1'b1;
        col_e = '0;
      end
      CH_FF: begin
        plan.clear = 1'b1;
        row_e      = '0;
        col_e      = '0;
      end
      CH_CR: begin
        col_e = '0;
      end
      default: begin
        plan.wr_en   = 1'b1;
        plan.wr_data = {1'b0, back_color, text_color, char_code};
        col_e        = col_e + 1'b1;
      end
    endcase

    // wrap past the last column, then scroll past the last row
    if (col_e >= COLUMNS) begin
      col_e = '0;
      row_e = row_e + 1'b1;
    end
    if (row_e >= ROWS) begin
      plan.scroll = 1'b1;
      row_e       = (ROW_W+1)'(ROWS - 1);
    end
    plan.row = row_e[ROW_W-1:0];
    plan.col = col_e[COL_W-1:0];
  end

endmodule

// ----- hdl/text_console_char_writer_top.sv -----
`timescale 1ns / 1ps
// Top level of the text console character writer: control, cursor and cell store.
//
//   channel | direction | protocol | contents
//   in_     | slave     | stream   | tuser func, tdata char/row/col
//   out_    | master    | stream   | tdata cursor row/col/linear, cell value
//   cfg_    | slave     | APB      | text_color at 0x0, back_color at 0x4
//
// A put of an ordinary or control character goes from ST_IDLE to ST_DONE; a read
// passes ST_RDATA in between for the registered RAM read; ST_DONE loads the result.
// Form feed fills all ROWS*COLUMNS cells, one per cycle, before ST_DONE.
// A scroll copies (ROWS-1)*COLUMNS cells through the RAM port and zeroes the
// bottom row. After reset a clearing pass over all cells holds in_tready low;
// configuration writes are taken at any time.
// A finished result waits in the output register while the next item is taken.
`include "assert_macros.svh"
module text_console_char_writer_top
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: char_code[7:0], row_index[12:8], col_index[19:13], zero pad
  input  logic [IN_DW-1:0]  in_tdata,
  // in_tuser: func[0]
  input  logic              in_tuser,
  input  logic              in_tvalid,
  output logic              in_tready,
  // out_tdata: cursor_row[4:0], cursor_col[11:5], cursor_linear[22:12],
  //            cell_value[38:23], zero pad
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  tcw_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic                fill_blank_r, fill_blank_nxt;
  logic [ROW_W-1:0]    cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [FG_W-1:0]     txt_color_r;
  logic [BG_W-1:0]     bak_color_r;
  logic                rd_ok_r, rd_ok_nxt;
  logic [CELL_W-1:0]   cell_r, cell_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]   out_data_r, out_data_nxt;

  logic                in_fire;
  logic                out_free;
  logic                cfg_wr;
  logic                in_func;
  logic [CHAR_W-1:0]   in_char;
  logic [ROW_W-1:0]    in_row;
  logic [COL_W-1:0]    in_col;
  logic                in_rd_ok;
  logic [LIN_W-1:0]    cur_lin;
  put_plan_t           plan;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  assign in_func  = in_tuser;
  assign in_char  = in_tdata[CHAR_W-1:0];
  assign in_row   = in_tdata[CHAR_W +: ROW_W];
  assign in_col   = in_tdata[CHAR_W+ROW_W +: COL_W];
  assign in_rd_ok = (in_row < ROWS) && (in_col < COLUMNS);

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cur_lin    = LIN_W'(cur_row_r) * LIN_W'(COLUMNS) + LIN_W'(cur_col_r);

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_BACK_COLOR) ?
                      CFG_DW'(bak_color_r) : CFG_DW'(txt_color_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txt_color_r <= FG_RESET;
      bak_color_r <= BG_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_TEXT_COLOR) begin
        txt_color_r <= cfg_pwdata[FG_W-1:0];
      end else begin
        bak_color_r <= cfg_pwdata[BG_W-1:0];
      end
    end
  end

  tcw_put_plan u_plan (
    .char_code  (in_char),
    .cur_row    (cur_row_r),
    .cur_col    (cur_col_r),
    .text_color (txt_color_r),
    .back_color (bak_color_r),
    .plan       (plan)
  );

  tcw_cell_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_READ) begin
            state_nxt = ST_RDATA;
          end else if (plan.clear) begin
            state_nxt = ST_FILL;
          end else if (plan.scroll) begin
            state_nxt = ST_COPY;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RDATA: state_nxt = ST_DONE;
      ST_FILL: begin
        if (cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = fill_blank_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_COPY: begin
        if (cnt_r == ADDR_W'(COPY_CELLS)) begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt        = cnt_r;
    fill_blank_nxt = fill_blank_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    rd_ok_nxt      = rd_ok_r;
    cell_nxt       = cell_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt = '0;
          if (in_func == FUNC_READ) begin
            ram_re    = in_rd_ok;
            ram_raddr = cell_addr(in_row, in_col);
            rd_ok_nxt = in_rd_ok;
          end else begin
            ram_we         = plan.wr_en;
            ram_waddr      = plan.wr_addr;
            ram_wdata      = plan.wr_data;
            cur_row_nxt    = plan.row;
            cur_col_nxt    = plan.col;
            fill_blank_nxt = 1'b1;
            cell_nxt       = '0;
          end
        end
      end
      ST_RDATA: begin
        cell_nxt = rd_ok_r ? ram_rdata : '0;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fill_blank_r ? BLANK_CELL : '0;
        cnt_nxt   = (cnt_r == ADDR_W'(CELL_COUNT - 1)) ? '0 : cnt_r + 1'b1;
      end
      ST_COPY: begin
        // read one row down, write back the cell read in the previous cycle
        if (cnt_r < ADDR_W'(COPY_CELLS)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r + ADDR_W'(COLUMNS);
          cnt_nxt   = cnt_r + 1'b1;
        end
        if (cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r - 1'b1;
          ram_wdata = ram_rdata;
        end
      end
      ST_ZERO: begin
        ram_we  = 1'b1;
        cnt_nxt = (cnt_r == ADDR_W'(CELL_COUNT - 1)) ? '0 : cnt_r + 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, cell_r, cur_lin, cur_col_r, cur_row_r};
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      cnt_r        <= '0;
      fill_blank_r <= 1'b0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      fill_blank_r <= fill_blank_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r    <= rd_ok_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

  `ASSERT_ALWAYS(a_cursor_range, (cur_row_r < ROWS) && (cur_col_r < COLUMNS), "cursor out of range")
  `ASSERT_NEXT(a_one_item, in_fire, !in_tready, "second item taken while one is at work")
  `ASSERT_NEXT(a_copy_to_zero, (state_r == ST_COPY) && (cnt_r == ADDR_W'(COPY_CELLS)), state_r == ST_ZERO, "scroll copy did not move on to bottom row")
  `ASSERT_ALWAYS(a_wr_addr_range, !ram_we || (ram_waddr < CELL_COUNT), "cell write beyond store")

endmodule
